/* rtl/mandelbrot_escape_color_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Mandelbrot escape color block
// Clocked property checks with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_COLOR_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_COLOR_TOP_ASSERT_SVH

// Check a property, masked while reset is high
`define MEC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included
`define MEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mec_pkg.sv */
// ----------------------------------------------------------------------------
// mec_pkg
// Shared types and constants of the Mandelbrot escape color block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mec_pkg;

  // Iteration cap register
  localparam int CAP_W = 13;
  localparam logic [CAP_W-1:0] CAP_MIN   = 13'd32;
  localparam logic [CAP_W-1:0] CAP_MAX   = 13'd4096;
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd192;

  // Palette mapping
  localparam int COLOR_W = 8;
  localparam logic [COLOR_W-1:0] PAL_BASE = 8'd16;
  localparam logic [COLOR_W-1:0] PAL_STEP = 8'd13;
  localparam logic [COLOR_W-1:0] PAL_SIZE = 8'd216;
  localparam logic [COLOR_W-1:0] COLOR_INSIDE = 8'd0;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // clear z, latch c and cap
    logic step;    // take one iteration of z
    logic square;  // form the products of the new z
    logic emit;    // register the result
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic stop;      // cap reached or magnitude escaped
    logic overflow;  // new z does not fit the coordinate width
  } dp_stat_t;

endpackage

/* rtl/mec_ctrl.sv */
// ----------------------------------------------------------------------------
// mec_ctrl
// Sequencer of the escape iteration: load, iterate, square, finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mec_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mec_pkg::dp_stat_t stat,
  output mec_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import mec_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ITER   = 4'b0010,
    S_SQUARE = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_ITER;
        end
      end
      S_ITER: begin
        if (stat.stop) begin
          state_next = S_FINISH;
        end else begin
          cmd.step   = 1'b1;
          state_next = stat.overflow ? S_FINISH : S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_ITER;
      end
      S_FINISH: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* rtl/mec_dp.sv */
// ----------------------------------------------------------------------------
// mec_dp
// Fixed-point datapath: z registers, squares, escape test, palette counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mec_dp #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mec_pkg::CAP_W-1:0]           cfg_wdata,
  input  logic signed [COORD_WIDTH-1:0]       point_re,
  input  logic signed [COORD_WIDTH-1:0]       point_im,
  input  mec_pkg::dp_cmd_t                    cmd,
  output mec_pkg::dp_stat_t                   stat,
  output logic [mec_pkg::COLOR_W-1:0]         color_index,
  output logic                                done
);
  import mec_pkg::*;

  localparam int PW = 2 * COORD_WIDTH;
  localparam int SW = 2 * COORD_WIDTH + 2;
  localparam logic [SW-1:0] LIMIT = SW'(1) << (2 * FRAC_BITS + 2);

  logic [CAP_W-1:0]             cap_reg;
  logic [CAP_W-1:0]             cap;
  logic [CAP_W-1:0]             iter;
  logic [COLOR_W-1:0]           pal;
  logic [COLOR_W:0]             pal_sum;
  logic [COLOR_W-1:0]           pal_next;
  logic signed [COORD_WIDTH-1:0] cre, cim, zre, zim;
  logic signed [PW-1:0]         x2, y2, xy;
  logic [SW-1:0]                mag;
  logic signed [SW-1:0]         diff, re_wide, im_wide, cre_wide, cim_wide;
  logic                         re_fits, im_fits;

  // Hold the iteration cap register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
    end else if (cfg_we) begin
      cap_reg <= cfg_wdata;
    end
  end

  // Escape test on the exact wide magnitude
  assign mag  = {2'b00, x2} + {2'b00, y2};
  assign stat.stop = (iter == cap) || (mag >= LIMIT);

  // Next z at extended width, then check it fits the coordinate width
  assign cre_wide = {{(SW-COORD_WIDTH){cre[COORD_WIDTH-1]}}, cre};
  assign cim_wide = {{(SW-COORD_WIDTH){cim[COORD_WIDTH-1]}}, cim};
  assign diff     = {{2{x2[PW-1]}}, x2} - {{2{y2[PW-1]}}, y2};
  assign re_wide  = (diff >>> FRAC_BITS) + cre_wide;
  assign im_wide  = ($signed({{2{xy[PW-1]}}, xy}) >>> (FRAC_BITS - 1)) + cim_wide;
  assign re_fits  = (re_wide[SW-1:COORD_WIDTH-1] ==
                     {(SW-COORD_WIDTH+1){re_wide[COORD_WIDTH-1]}});
  assign im_fits  = (im_wide[SW-1:COORD_WIDTH-1] ==
                     {(SW-COORD_WIDTH+1){im_wide[COORD_WIDTH-1]}});
  assign stat.overflow = !(re_fits && im_fits);

  // Advance the palette offset by one step modulo the palette size
  assign pal_sum  = {1'b0, pal} + {1'b0, PAL_STEP};
  assign pal_next = (pal_sum >= {1'b0, PAL_SIZE}) ?
                    COLOR_W'(pal_sum - {1'b0, PAL_SIZE}) : COLOR_W'(pal_sum);

  // Iteration state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cre  <= point_re;
      cim  <= point_im;
      zre  <= '0;
      zim  <= '0;
      x2   <= '0;
      y2   <= '0;
      xy   <= '0;
      iter <= '0;
      pal  <= '0;
      if (cap_reg < CAP_MIN) begin
        cap <= CAP_MIN;
      end else if (cap_reg > CAP_MAX) begin
        cap <= CAP_MAX;
      end else begin
        cap <= cap_reg;
      end
    end else begin
      if (cmd.step) begin
        zre  <= re_wide[COORD_WIDTH-1:0];
        zim  <= im_wide[COORD_WIDTH-1:0];
        iter <= iter + 1'b1;
        pal  <= pal_next;
      end
      if (cmd.square) begin
        x2 <= zre * zre;
        y2 <= zim * zim;
        xy <= zre * zim;
      end
    end
  end

  // Register the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  // Register the result color
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      color_index <= (iter == cap) ? COLOR_INSIDE : PAL_BASE + pal;
    end
  end

endmodule

/* rtl/mandelbrot_escape_color_top.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_color_top
// Escape-time color of one complex point under z = z*z + c.
// ----------------------------------------------------------------------------
//   channel   handshake          payload
//   input     start, busy        point_re, point_im
//   result    done (one cycle)   color_index
//   config    cfg_we             cfg_wdata (iteration cap)
//
// An iteration that leaves the coordinate range ends the item without the
// square step. Each iteration passes through the update and escape test and
// then through the three square multipliers.
// Reset clears the cap to 192 and returns the sequencer to idle.
// The result strobe cannot be stalled; busy stays high until done.
`timescale 1ns / 1ps

module mandelbrot_escape_color_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mec_pkg::CAP_W-1:0]     cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_re,
  input  logic signed [COORD_WIDTH-1:0] point_im,
  output logic                          done,
  output logic [mec_pkg::COLOR_W-1:0]   color_index
);
  import mec_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  mec_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath
  mec_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .point_re    (point_re),
    .point_im    (point_im),
    .cmd         (cmd),
    .stat        (stat),
    .color_index (color_index),
    .done        (done)
  );

endmodule

/* rtl/mec_check.sv */
// ----------------------------------------------------------------------------
// mec_check
// Port-level checks of the escape color block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mandelbrot_escape_color_top_assert.svh"

module mec_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [mec_pkg::COLOR_W-1:0] color_index
);
  import mec_pkg::*;

  // Reset leaves the block idle with no result pending
  `MEC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (!busy && !done), "not idle after reset")

  // An accepted item keeps the block busy
  `MEC_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> (busy && !done), "accept without busy")

  // A result is a single-cycle strobe
  `MEC_ASSERT(a_done_pulse, clk, rst, done |=> !done, "result strobe longer than one cycle")

  // A result color is inside or within the palette range
  `MEC_ASSERT(a_color_range, clk, rst, done |-> ((color_index == COLOR_INSIDE) || ((color_index >= 8'd16) && (color_index <= 8'd231))), "color out of range")

endmodule

bind mandelbrot_escape_color_top mec_check u_check (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .color_index (color_index)
);

/* test/mec_color_checker.sv */
// ----------------------------------------------------------------------------
// mec_color_checker
// Watches the point, result and cap channels of the escape color block,
// predicts the palette index of every accepted point and compares it with
// the result strobed out, counting every mismatch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mec_color_checker #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mec_pkg::CAP_W-1:0]     cfg_wdata,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_re,
  input  logic signed [COORD_WIDTH-1:0] point_im,
  input  logic                          done,
  input  logic [mec_pkg::COLOR_W-1:0]   color_index,
  output int                            fail_count,
  output int                            pending
);

  import mec_pkg::*;

  typedef logic signed [127:0] wide_t;

  // 4.0 at the fraction width of a square, and the coordinate range
  localparam wide_t ESCAPE_LIMIT = 128'sd1 <<< (2 * FRAC_BITS + 2);
  localparam wide_t COORD_HI     = 128'sd1 <<< (COORD_WIDTH - 1);
  localparam wide_t COORD_LO     = -COORD_HI;

  logic [CAP_W-1:0]   cap_setting;
  logic [COLOR_W-1:0] expected_colors[$];
  logic [COLOR_W-1:0] want_color;
  int                 result_count;

  // Clamp the register to the range the sequencer honors
  function automatic int effective_cap(logic [CAP_W-1:0] setting);
    if (setting < CAP_MIN) return int'(CAP_MIN);
    if (setting > CAP_MAX) return int'(CAP_MAX);
    return int'(setting);
  endfunction

  function automatic bit in_coord(wide_t v);
    return v >= COORD_LO && v < COORD_HI;
  endfunction

  // Iterate z = z*z + c from zero; return the iteration count at the stop
  function automatic int escape_steps(logic signed [COORD_WIDTH-1:0] c_re,
                                      logic signed [COORD_WIDTH-1:0] c_im,
                                      int cap);
    wide_t cr, ci, zr, zi, x2, y2, nr, ni;
    int    steps;
    bit    overflow;
    cr = c_re;
    ci = c_im;
    zr = '0;
    zi = '0;
    x2 = '0;
    y2 = '0;
    steps = 0;
    overflow = 1'b0;
    while (!overflow && steps < cap && (x2 + y2) < ESCAPE_LIMIT) begin
      ni = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
      nr = ((x2 - y2) >>> FRAC_BITS) + cr;
      steps++;
      // a coordinate that leaves the range counts as an escape
      if (!in_coord(ni) || !in_coord(nr)) begin
        overflow = 1'b1;
      end else begin
        zr = nr;
        zi = ni;
        x2 = zr * zr;
        y2 = zi * zi;
      end
    end
    return steps;
  endfunction

  // Map an iteration count to the palette; a capped point is inside
  function automatic logic [COLOR_W-1:0] palette_color(int steps, int cap);
    int idx;
    if (steps == cap) return COLOR_INSIDE;
    idx = int'(PAL_BASE) + (steps * int'(PAL_STEP)) % int'(PAL_SIZE);
    return idx[COLOR_W-1:0];
  endfunction

  task automatic flag_error(string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Track the cap, queue predicted colors, compare strobed results
  always @(posedge clk) begin
    if (rst) begin
      cap_setting <= CAP_RESET;
      expected_colors.delete();
      result_count = 0;
      pending = 0;
    end else begin
      if (done) begin
        if (expected_colors.size() == 0) begin
          flag_error($sformatf("color_index %0d strobed with no point pending",
                               color_index));
        end else begin
          want_color = expected_colors.pop_front();
          if (color_index !== want_color)
            flag_error($sformatf("result %0d: color_index %0d, expected %0d",
                                 result_count, color_index, want_color));
        end
        result_count++;
      end
      if (start && !busy)
        expected_colors.push_back(palette_color(
          escape_steps(point_re, point_im, effective_cap(cap_setting)),
          effective_cap(cap_setting)));
      if (cfg_we) cap_setting <= cfg_wdata;
      pending = expected_colors.size();
    end
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives complex points into the escape color block across several iteration
// caps: a directed set of extremes, overflows and points that escape right at
// the cap, then random points biased toward the set boundary. A checker
// predicts each palette index; this module reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import mec_pkg::*;

  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 28;
  localparam int STALL_LIMIT = 40000;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CAP_W-1:0]          cfg_wdata;
  logic                      start;
  logic                      busy;
  logic signed [COORD_W-1:0] point_re;
  logic signed [COORD_W-1:0] point_im;
  logic                      done;
  logic [COLOR_W-1:0]        color_index;
  int                        fail_count;
  int                        pending;
  int                        idle_cycles;
  bit                        idle_on;

  mandelbrot_escape_color_top #(
    .COORD_WIDTH(COORD_W),
    .FRAC_BITS  (FRAC_W)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .busy       (busy),
    .point_re   (point_re),
    .point_im   (point_im),
    .done       (done),
    .color_index(color_index)
  );

  mec_color_checker #(
    .COORD_WIDTH(COORD_W),
    .FRAC_BITS  (FRAC_W)
  ) color_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .busy       (busy),
    .point_re   (point_re),
    .point_im   (point_im),
    .done       (done),
    .color_index(color_index),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Hold one point on the inputs until the block takes it
  task automatic send_point(input logic signed [COORD_W-1:0] re,
                            input logic signed [COORD_W-1:0] im);
    if (idle_on && $urandom_range(99) < 22) begin
      start <= 1'b0;
      if ($urandom_range(1) == 1)
        while (busy) @(negedge clk);
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start    <= 1'b1;
    point_re <= re;
    point_im <= im;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Mostly points near the set, some at the cusp, the rest anywhere
  task automatic random_point(output logic signed [COORD_W-1:0] re,
                              output logic signed [COORD_W-1:0] im);
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      re = int'($urandom_range(805306368)) - 603979776;
      im = int'($urandom_range(805306368)) - 402653184;
    end else if (pick < 75) begin
      re = 67108864 + int'($urandom_range(4194304));
      im = int'($urandom_range(2097152)) - 1048576;
    end else begin
      re = $urandom;
      im = $urandom;
    end
  endtask

  task automatic run_random(input int count);
    logic signed [COORD_W-1:0] re, im;
    repeat (count) begin
      random_point(re, im);
      send_point(re, im);
    end
  endtask

  // Drop start and let every pending color come out
  task automatic drain();
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Walk right of the cusp on the real axis until a point escapes
  // after exactly the wanted number of iterations
  function automatic logic signed [COORD_W-1:0] real_axis_point(int target,
                                                                int stride);
    logic signed [COORD_W-1:0] c;
    for (int k = 1; k < 4000; k++) begin
      c = 32'sh0400_0000 + k * stride;
      if (color_check.escape_steps(c, 32'sd0, int'(CAP_MAX)) == target) return c;
    end
    return 32'sh0400_0000 + stride;
  endfunction

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    start     = 1'b0;
    point_re  = '0;
    point_im  = '0;
    idle_on   = 1'b1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset cap: extremes, overflows, fixed points, escapes at the cap
    send_point(32'sd0, 32'sd0);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sd0);
    send_point(32'sd0, 32'sh8000_0000);
    send_point(32'sh7FFF_FFFF, 32'sd0);
    send_point(32'sd0, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(32'shE000_0000, 32'sd0);
    send_point(32'sh0400_0000, 32'sd0);
    send_point(32'shF400_0000, 32'sd26843546);
    send_point(32'sd2120640512, 32'sd0);
    send_point(32'sh7000_0000, 32'sh7000_0000);
    send_point(32'sd0, 32'sd2120640512);
    send_point(32'shF000_0000, 32'sd0);
    send_point(32'sd0, 32'sh1000_0000);
    send_point(32'sh2000_0000, 32'sd0);
    send_point(32'sd1, 32'shFFFF_FFFF);
    send_point(real_axis_point(192, 256), 32'sd0);
    send_point(real_axis_point(191, 256), 32'sd0);
    send_point(real_axis_point(193, 256), 32'sd0);
    run_random(25);

    // Cap below range acts as the minimum
    write_cap(13'd0);
    send_point(real_axis_point(32, 16384), 32'sd0);
    send_point(real_axis_point(31, 16384), 32'sd0);
    send_point(real_axis_point(33, 16384), 32'sd0);
    send_point(32'sd0, 32'sd0);
    run_random(25);

    // Largest cap: keep the count low, inside points are slow
    write_cap(CAP_MAX);
    send_point(32'sd0, 32'sd0);
    send_point(32'sh0400_0000, 32'sd0);
    run_random(8);

    // All ones acts as the maximum
    write_cap(13'h1FFF);
    send_point(32'sd0, 32'sd0);
    run_random(5);

    write_cap(13'd31);
    run_random(15);

    // Back-to-back points with no gaps
    idle_on = 1'b0;
    write_cap(CAP_MIN);
    run_random(20);
    idle_on = 1'b1;

    write_cap(13'($urandom_range(33, 400)));
    run_random(12);

    write_cap(13'd4097);
    send_point(32'sd0, 32'sd0);
    run_random(1);

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/mec_pkg.sv
rtl/mec_ctrl.sv
rtl/mec_dp.sv
rtl/mandelbrot_escape_color_top.sv
rtl/mec_check.sv
test/mec_color_checker.sv
test/tb.sv
